// ===== hw/rtl/ihs_pkg.sv =====
package ihs_pkg;

    // Default width of the byte position counter.
    localparam int IHS_OFFSET_BITS = 32;

    // Format codes reported with every result.
    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_PNG     = 2'd1;
    localparam logic [1:0] FMT_JPEG    = 2'd2;
    localparam logic [1:0] FMT_BMP     = 2'd3;

    // One result of a finished file.
    typedef struct packed {
        logic signed [31:0] height;
        logic        [30:0] width;
        logic        [1:0]  format;
    } t_result;

endpackage

// ===== hw/rtl/ihs_parser.sv =====
module ihs_parser #(
    parameter int OFFSET_BITS = ihs_pkg::IHS_OFFSET_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output ihs_pkg::t_result o_result
);
    import ihs_pkg::*;

    typedef enum logic [2:0] {
        PH_EXPECT_FF  = 3'd0,
        PH_MARKER     = 3'd1,
        PH_LEN_HIGH   = 3'd2,
        PH_LEN_LOW    = 3'd3,
        PH_BODY       = 3'd4
    } t_phase;

    localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};
    localparam logic [7:0] IHDR_TAG [4] = '{8'd73, 8'd72, 8'd68, 8'd82};

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_D0  = 8'hD0;
    localparam logic [7:0] BYTE_D8  = 8'hD8;
    localparam logic [7:0] BYTE_EOI = 8'hD9;
    localparam logic [7:0] BYTE_SOF = 8'hC0;
    localparam logic [7:0] BYTE_B   = 8'h42;
    localparam logic [7:0] BYTE_M   = 8'h4D;

    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [1:0]             r_format, n_format;
    logic                   r_match, n_match;
    t_phase                 r_phase, n_phase;
    logic [7:0]             r_marker, n_marker;
    logic [15:0]            r_seg_left, n_seg_left;
    logic [15:0]            r_seg_idx, n_seg_idx;
    logic [31:0]            r_width, n_width;
    logic [31:0]            r_height, n_height;
    logic                   r_done, n_done;

    // Replace one byte lane of a 32-bit accumulator.
    function automatic logic [31:0] put_lane(input logic [31:0] acc,
                                             input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] res;
        res = acc;
        case (lane)
            2'd0:    res[7:0]   = b;
            2'd1:    res[15:8]  = b;
            2'd2:    res[23:16] = b;
            default: res[31:24] = b;
        endcase
        return res;
    endfunction

    always_comb begin
        logic [OFFSET_BITS-1:0] o;
        logic [15:0]            seg_len;
        logic [15:0]            left_dec;
        o          = r_offset;
        seg_len    = {r_seg_left[7:0], i_byte};
        left_dec   = r_seg_left - 16'd1;
        n_offset   = (r_offset != '1) ? r_offset + OFFSET_BITS'(1) : r_offset;
        n_format   = r_format;
        n_match    = r_match;
        n_phase    = r_phase;
        n_marker   = r_marker;
        n_seg_left = r_seg_left;
        n_seg_idx  = r_seg_idx;
        n_width    = r_width;
        n_height   = r_height;
        n_done     = r_done;

        if (o == '0) begin
            if (i_byte == PNG_SIG[0]) begin
                n_format = FMT_PNG;
            end else if (i_byte == BYTE_FF) begin
                n_format = FMT_JPEG;
            end else if (i_byte == BYTE_B) begin
                n_format = FMT_BMP;
            end else begin
                n_format = FMT_UNKNOWN;
                n_match  = 1'b0;
            end
        end else if (r_match) begin
            case (r_format)
                FMT_PNG: begin
                    if (o < OFFSET_BITS'(8)) begin
                        if (i_byte != PNG_SIG[o[2:0]]) n_match = 1'b0;
                    end else if (o >= OFFSET_BITS'(12) && o < OFFSET_BITS'(16)) begin
                        if (i_byte != IHDR_TAG[o[1:0]]) n_match = 1'b0;
                    end else if (o >= OFFSET_BITS'(16) && o < OFFSET_BITS'(20)) begin
                        // Big-endian: the first size byte lands in the top lane.
                        n_width = put_lane(r_width, ~o[1:0], i_byte);
                    end else if (o >= OFFSET_BITS'(20) && o < OFFSET_BITS'(24)) begin
                        n_height = put_lane(r_height, ~o[1:0], i_byte);
                    end
                end
                FMT_JPEG: begin
                    if (o == OFFSET_BITS'(1)) begin
                        if (i_byte != BYTE_D8) n_match = 1'b0;
                    end else if (o == OFFSET_BITS'(2)) begin
                        if (i_byte != BYTE_FF) n_match = 1'b0;
                        else n_phase = PH_MARKER;
                    end else if (!r_done) begin
                        case (r_phase)
                            PH_MARKER: begin
                                // Fill bytes of FF are skipped.
                                if (i_byte != BYTE_FF) begin
                                    n_marker = i_byte;
                                    if (i_byte == BYTE_EOI) begin
                                        n_done  = 1'b1;
                                        n_phase = PH_EXPECT_FF;
                                    end else if (i_byte >= BYTE_D0 && i_byte <= BYTE_D8) begin
                                        n_phase = PH_EXPECT_FF;
                                    end else begin
                                        n_phase = PH_LEN_HIGH;
                                    end
                                end
                            end
                            PH_LEN_HIGH: begin
                                n_seg_left = {8'd0, i_byte};
                                n_phase    = PH_LEN_LOW;
                            end
                            PH_LEN_LOW: begin
                                n_seg_idx = 16'd0;
                                if (seg_len <= 16'd2) begin
                                    n_seg_left = 16'd0;
                                    n_phase    = PH_EXPECT_FF;
                                end else begin
                                    n_seg_left = seg_len - 16'd2;
                                    n_phase    = PH_BODY;
                                end
                            end
                            PH_BODY: begin
                                if (r_marker == BYTE_SOF) begin
                                    if (r_seg_idx == 16'd1) begin
                                        n_height = {16'd0, i_byte, 8'd0};
                                    end else if (r_seg_idx == 16'd2) begin
                                        n_height = {r_height[31:8], i_byte};
                                    end else if (r_seg_idx == 16'd3) begin
                                        n_width = {16'd0, i_byte, 8'd0};
                                    end else if (r_seg_idx == 16'd4) begin
                                        n_width = {r_width[31:8], i_byte};
                                    end
                                end
                                n_seg_idx  = r_seg_idx + 16'd1;
                                n_seg_left = left_dec;
                                if (left_dec == 16'd0) n_phase = PH_EXPECT_FF;
                            end
                            default: begin
                                n_phase = (i_byte == BYTE_FF) ? PH_MARKER : PH_EXPECT_FF;
                            end
                        endcase
                    end
                end
                FMT_BMP: begin
                    if (o == OFFSET_BITS'(1)) begin
                        if (i_byte != BYTE_M) n_match = 1'b0;
                    end else if (o >= OFFSET_BITS'(18) && o < OFFSET_BITS'(22)) begin
                        // Little-endian: offset 18 is the low lane.
                        n_width = put_lane(r_width, o[1:0] ^ 2'b10, i_byte);
                    end else if (o >= OFFSET_BITS'(22) && o < OFFSET_BITS'(26)) begin
                        n_height = put_lane(r_height, o[1:0] ^ 2'b10, i_byte);
                    end
                end
                default: begin
                end
            endcase
        end

        // Result as seen with this byte's updates applied.
        o_result = '0;
        if (n_match) begin
            if (n_format == FMT_PNG && o >= OFFSET_BITS'(15)) begin
                o_result.format = FMT_PNG;
                o_result.width  = n_width[31] ? 31'h7FFF_FFFF : n_width[30:0];
                o_result.height = n_height[31] ? 32'sh7FFF_FFFF : $signed(n_height);
            end else if (n_format == FMT_JPEG && o >= OFFSET_BITS'(2)) begin
                o_result.format = FMT_JPEG;
                o_result.width  = {15'd0, n_width[15:0]};
                o_result.height = $signed({16'd0, n_height[15:0]});
            end else if (n_format == FMT_BMP && o >= OFFSET_BITS'(1)) begin
                o_result.format = FMT_BMP;
                o_result.width  = n_width[31] ? 31'd0 : n_width[30:0];
                o_result.height = $signed(n_height);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_offset   <= '0;
            r_format   <= FMT_UNKNOWN;
            r_match    <= 1'b1;
            r_phase    <= PH_EXPECT_FF;
            r_marker   <= 8'd0;
            r_seg_left <= 16'd0;
            r_seg_idx  <= 16'd0;
            r_width    <= 32'd0;
            r_height   <= 32'd0;
            r_done     <= 1'b0;
        end else if (i_step) begin
            r_offset   <= n_offset;
            r_format   <= n_format;
            r_match    <= n_match;
            r_phase    <= n_phase;
            r_marker   <= n_marker;
            r_seg_left <= n_seg_left;
            r_seg_idx  <= n_seg_idx;
            r_width    <= n_width;
            r_height   <= n_height;
            r_done     <= n_done;
        end
    end

endmodule

// ===== hw/rtl/image_header_size_sniffer_top.sv =====
// Image header sniffer: reads an image file one byte per transfer and reports
// its format (unknown, PNG, JPEG or BMP) with pixel width and height.
// The slave channel carries one file byte in s_axis_tdata; s_axis_tlast marks
// the final byte of a file. The master channel carries one result per file,
// sent only after the byte marked last.
// A byte is first captured in an input register; as it advances from there,
// the parser updates its header state and, for a last byte, loads the
// result register. One byte is taken every cycle while no last byte waits
// on a pending result: the parser does one short update per byte, so
// throughput is one byte per clock.
// When the receiver stalls with a result pending, bytes of the next file keep
// flowing; only a further last byte waits in the input register until the
// pending result is taken, which then holds the slave side too.
// After a last byte all parser state returns to its reset values, so the next
// byte starts a new file. Reset (i_rst_n low at a clock edge) empties both
// registers and restarts the parser.
module image_header_size_sniffer_top #(
    parameter int OFFSET_BITS = ihs_pkg::IHS_OFFSET_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // [1:0] image_format, [32:2] image_width,
                                       // [64:33] image_height, [71:65] zero
);
    import ihs_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    parse_result;
    logic       out_free;
    logic       advance;

    // The held byte moves on unless it would produce a result with the
    // result register still occupied.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    ihs_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_result(parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= parse_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

endmodule
